// ===== sv/bfra_pkg.sv =====
// Shared constants and types for the best-fit range allocator.
// No dependencies.
package bfra_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int ADDR_BITS  = 32;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam logic [31:0] POOL_RESET = 32'd65536;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADOFF = 2'd3;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] length;
    logic                 free;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

endpackage

// ===== sv/bfra_table.sv =====
// Block table: one entry per contiguous range, one read and one write port.
// Depends on bfra_pkg.
module bfra_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bfra_pkg::IDX_W-1:0] rd_idx_i,
  output bfra_pkg::entry_t          rd_entry_o,
  input  bfra_pkg::tbl_wr_t         wr_i
);
  import bfra_pkg::*;

  entry_t mem_q [MAX_BLOCKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        mem_q[k] <= '0;
      end
      mem_q[0] <= '{start: '0, length: ADDR_BITS'(POOL_RESET), free: 1'b1};
    end else if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_entry_o = mem_q[rd_idx_i];

endmodule

// ===== sv/best_fit_range_allocator.sv =====
// Best-fit range allocator top level: request sequencer over the block table.
// Depends on bfra_pkg and bfra_table.
//
// Usage: present operation_i, request_size_i and block_offset_i with start
// high while busy is low; that edge accepts the transaction. busy stays high
// while the sequencer works. The result appears on status_o and
// granted_offset_o, which hold it until the next result, with done_o high
// for exactly one cycle; the receiver cannot stall it, and a new request may
// be accepted in that same cycle. Allocate scans all used table entries, then
// on a split shifts later entries up by one, or reports ST_FULL when the
// table is full. Free scans up to the match, then moves entries down for
// each merge. Init and the reserved operation finish without leaving idle.
// Every step reads one entry through the single table read port. cfg_we_i
// writes the pool size register, used by init only; reset loads POOL_RESET.
// Reset leaves one free block [0, 65536) and an idle sequencer.
module best_fit_range_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [bfra_pkg::ADDR_BITS-1:0] request_size_i,
  input  logic [bfra_pkg::ADDR_BITS-1:0] block_offset_i,
  input  logic                          cfg_we_i,
  input  logic [31:0]                   cfg_wdata_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [bfra_pkg::ADDR_BITS-1:0] granted_offset_o
);
  import bfra_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN_A = 4'd1;
  localparam logic [3:0] S_DEC_A  = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_SPLIT  = 4'd4;
  localparam logic [3:0] S_SCAN_F = 4'd5;
  localparam logic [3:0] S_F_SUCC = 4'd6;
  localparam logic [3:0] S_F_PRED = 4'd7;
  localparam logic [3:0] S_RM     = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d, i_q, i_d;
  logic [IDX_W-1:0]     best_q, best_d, idx_q, idx_d;
  logic                 bestv_q, bestv_d, pred_q, pred_d;
  entry_t               best_ent_q, best_ent_d;
  logic [ADDR_BITS-1:0] size_q, size_d, off_q, off_d, cur_len_q, cur_len_d;
  logic [ADDR_BITS-1:0] cur_start_q, cur_start_d;
  logic [31:0]          pool_q;
  logic                 done_q, done_d;
  logic [1:0]           status_q, status_d;
  logic [ADDR_BITS-1:0] grant_q, grant_d;

  logic [IDX_W-1:0] rd_idx;
  entry_t           rd;
  tbl_wr_t          wr;
  logic [CNT_W-1:0] bp1, ip1;

  bfra_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd),
    .wr_i       (wr)
  );

  assign bp1 = {1'b0, best_q} + CNT_W'(1);
  assign ip1 = {1'b0, idx_q} + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    best_d      = best_q;
    bestv_d     = bestv_q;
    best_ent_d  = best_ent_q;
    idx_d       = idx_q;
    pred_d      = pred_q;
    size_d      = size_q;
    off_d       = off_q;
    cur_len_d   = cur_len_q;
    cur_start_d = cur_start_q;
    done_d      = 1'b0;
    status_d    = status_q;
    grant_d     = grant_q;
    rd_idx      = i_q[IDX_W-1:0];
    wr          = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          size_d = request_size_i;
          off_d  = block_offset_i;
          i_d    = '0;
          case (operation_i)
            OP_ALLOC: begin
              if (request_size_i == '0) begin
                done_d   = 1'b1;
                status_d = ST_NOFIT;
                grant_d  = '0;
              end else begin
                bestv_d = 1'b0;
                state_d = S_SCAN_A;
              end
            end
            OP_FREE: state_d = S_SCAN_F;
            OP_INIT: begin
              wr.en   = 1'b1;
              wr.idx  = '0;
              wr.data = '{start: '0, length: ADDR_BITS'(pool_q), free: 1'b1};
              cnt_d    = CNT_W'(1);
              done_d   = 1'b1;
              status_d = ST_OK;
              grant_d  = '0;
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_OK;
              grant_d  = '0;
            end
          endcase
        end
      end
      S_SCAN_A: begin
        if (i_q == cnt_q) begin
          state_d = S_DEC_A;
        end else begin
          if (rd.free && rd.length >= size_q &&
              (!bestv_q || rd.length < best_ent_q.length)) begin
            best_d     = i_q[IDX_W-1:0];
            best_ent_d = rd;
            bestv_d    = 1'b1;
          end
          i_d = i_q + CNT_W'(1);
        end
      end
      S_DEC_A: begin
        if (!bestv_q) begin
          done_d   = 1'b1;
          status_d = ST_NOFIT;
          grant_d  = '0;
          state_d  = S_IDLE;
        end else if (best_ent_q.length == size_q) begin
          wr.en    = 1'b1;
          wr.idx   = best_q;
          wr.data  = '{start: best_ent_q.start, length: best_ent_q.length, free: 1'b0};
          done_d   = 1'b1;
          status_d = ST_OK;
          grant_d  = best_ent_q.start;
          state_d  = S_IDLE;
        end else if (cnt_q == CNT_W'(MAX_BLOCKS)) begin
          done_d   = 1'b1;
          status_d = ST_FULL;
          grant_d  = '0;
          state_d  = S_IDLE;
        end else begin
          i_d     = cnt_q;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (i_q > bp1) begin
          rd_idx  = IDX_W'(i_q - CNT_W'(1));
          wr.en   = 1'b1;
          wr.idx  = i_q[IDX_W-1:0];
          wr.data = rd;
          i_d     = i_q - CNT_W'(1);
        end else begin
          wr.en   = 1'b1;
          wr.idx  = bp1[IDX_W-1:0];
          wr.data = '{start: best_ent_q.start + size_q,
                      length: best_ent_q.length - size_q, free: 1'b1};
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        wr.en    = 1'b1;
        wr.idx   = best_q;
        wr.data  = '{start: best_ent_q.start, length: size_q, free: 1'b0};
        cnt_d    = cnt_q + CNT_W'(1);
        done_d   = 1'b1;
        status_d = ST_OK;
        grant_d  = best_ent_q.start;
        state_d  = S_IDLE;
      end
      S_SCAN_F: begin
        if (i_q == cnt_q) begin
          done_d   = 1'b1;
          status_d = ST_BADOFF;
          grant_d  = '0;
          state_d  = S_IDLE;
        end else if (!rd.free && rd.start == off_q) begin
          idx_d       = i_q[IDX_W-1:0];
          cur_len_d   = rd.length;
          cur_start_d = rd.start;
          wr.en       = 1'b1;
          wr.idx      = i_q[IDX_W-1:0];
          wr.data     = '{start: rd.start, length: rd.length, free: 1'b1};
          state_d     = S_F_SUCC;
        end else begin
          i_d = i_q + CNT_W'(1);
        end
      end
      S_F_SUCC: begin
        rd_idx  = ip1[IDX_W-1:0];
        state_d = S_F_PRED;
        if (ip1 < cnt_q && rd.free) begin
          cur_len_d = cur_len_q + rd.length;
          wr.en     = 1'b1;
          wr.idx    = idx_q;
          wr.data   = '{start: cur_start_q, length: cur_len_q + rd.length, free: 1'b1};
          i_d       = ip1;
          pred_d    = 1'b0;
          state_d   = S_RM;
        end
      end
      S_F_PRED: begin
        rd_idx = idx_q - IDX_W'(1);
        if (idx_q != '0 && rd.free) begin
          wr.en   = 1'b1;
          wr.idx  = idx_q - IDX_W'(1);
          wr.data = '{start: rd.start, length: rd.length + cur_len_q, free: 1'b1};
          i_d     = {1'b0, idx_q};
          pred_d  = 1'b1;
          state_d = S_RM;
        end else begin
          done_d   = 1'b1;
          status_d = ST_OK;
          grant_d  = '0;
          state_d  = S_IDLE;
        end
      end
      S_RM: begin
        if (i_q + CNT_W'(1) < cnt_q) begin
          rd_idx  = IDX_W'(i_q + CNT_W'(1));
          wr.en   = 1'b1;
          wr.idx  = i_q[IDX_W-1:0];
          wr.data = rd;
          i_d     = i_q + CNT_W'(1);
        end else begin
          wr.en   = 1'b1;
          wr.idx  = i_q[IDX_W-1:0];
          wr.data = '0;
          cnt_d   = cnt_q - CNT_W'(1);
          if (pred_q) begin
            done_d   = 1'b1;
            status_d = ST_OK;
            grant_d  = '0;
            state_d  = S_IDLE;
          end else begin
            state_d = S_F_PRED;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CNT_W'(1);
      pool_q  <= POOL_RESET;
      done_q  <= 1'b0;
      bestv_q <= 1'b0;
      pred_q  <= 1'b0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      bestv_q <= bestv_d;
      pred_q  <= pred_d;
      i_q     <= i_d;
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_ent_q  <= best_ent_d;
    idx_q       <= idx_d;
    size_q      <= size_d;
    off_q       <= off_d;
    cur_len_q   <= cur_len_d;
    cur_start_q <= cur_start_d;
    status_q    <= status_d;
    grant_q     <= grant_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_offset_o = grant_q;

endmodule
